@@ design/bme_pkg.sv @@
// ============================================================================
// bme_pkg
// Types, constants and helper functions shared by the bitset membership
// engine.
// ============================================================================
package bme_pkg;

    localparam int WORD_W        = 64;
    localparam int NUM_WORDS_DEF = 64;
    localparam int IDX_W         = 6;
    localparam int POS_W         = 6;
    localparam int BIT_IDX_W     = 12;
    localparam int IDX_EXT_W     = 11;
    localparam int COUNT_W       = 13;
    localparam int POPC_W        = 7;
    localparam int ACTION_W      = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 24;
    localparam int RES_W     = 17;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [ACTION_W-1:0] ACT_TEST  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OR    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ENUM  = 3'd5;

    typedef enum logic [2:0] {
        OP_TEST,
        OP_SET,
        OP_CLEAR,
        OP_OR,
        OP_QUERY,
        OP_ENUM,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              oor;
        logic [IDX_W-1:0]  word_idx;
        logic [POS_W-1:0]  bit_pos;
        logic [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic                 member_valid;
        logic [BIT_IDX_W-1:0] member_index;
        logic                 at_least_two;
        logic                 is_empty;
        logic                 oor;
        logic                 flag;
    } t_result;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_FETCH,
        ST_EXEC,
        ST_ENUM
    } t_bstate;

    function automatic logic [POS_W-1:0] lowest_bit(input logic [WORD_W-1:0] x_in);
        logic [WORD_W-1:0] x;
        logic [POS_W-1:0]  n;
        x = x_in;
        n = '0;
        if ((x & 64'hFFFF_FFFF) == '0) begin
            x = x >> 32;
            n = n + POS_W'(32);
        end
        if ((x & 64'hFFFF) == '0) begin
            x = x >> 16;
            n = n + POS_W'(16);
        end
        if ((x & 64'hFF) == '0) begin
            x = x >> 8;
            n = n + POS_W'(8);
        end
        if ((x & 64'hF) == '0) begin
            x = x >> 4;
            n = n + POS_W'(4);
        end
        if ((x & 64'h3) == '0) begin
            x = x >> 2;
            n = n + POS_W'(2);
        end
        if ((x & 64'h1) == '0) begin
            n = n + POS_W'(1);
        end
        return n;
    endfunction

    function automatic logic [POPC_W-1:0] popcount(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
        logic [WORD_W-1:0] f;
        a = (x & 64'h5555_5555_5555_5555) + ((x >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b & 64'h0F0F_0F0F_0F0F_0F0F) + ((b >> 4) & 64'h0F0F_0F0F_0F0F_0F0F);
        d = (c & 64'h00FF_00FF_00FF_00FF) + ((c >> 8) & 64'h00FF_00FF_00FF_00FF);
        e = (d & 64'h0000_FFFF_0000_FFFF) + ((d >> 16) & 64'h0000_FFFF_0000_FFFF);
        f = (e & 64'h0000_0000_FFFF_FFFF) + (e >> 32);
        return f[POPC_W-1:0];
    endfunction

endpackage

@@ design/bme_front.sv @@
// ============================================================================
// bme_front
// Accepts input transactions and classifies them into commands: decodes the
// action, picks the word slot and checks it against capacity.
// ============================================================================
module bme_front
    import bme_pkg::*;
#(
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bit_index[11:0], word_index[17:12], word_value[81:18], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    localparam logic [IDX_EXT_W-1:0] NW = IDX_EXT_W'(NUM_WORDS);

    logic [BIT_IDX_W-1:0] bit_index;
    logic [IDX_W-1:0]     word_index;
    logic [IDX_W-1:0]     sel_idx;
    logic                 idx_oor;

    assign bit_index  = s_tdata[11:0];
    assign word_index = s_tdata[17:12];

    assign s_tready = !i_q_full;
    assign o_push   = s_tvalid && !i_q_full;

    always_comb begin
        o_cmd.op  = OP_NOP;
        sel_idx   = word_index;
        unique case (s_tuser)
            ACT_TEST: begin
                o_cmd.op = OP_TEST;
                sel_idx  = bit_index[11:6];
            end
            ACT_SET: begin
                o_cmd.op = OP_SET;
                sel_idx  = bit_index[11:6];
            end
            ACT_CLEAR: o_cmd.op = OP_CLEAR;
            ACT_OR:    o_cmd.op = OP_OR;
            ACT_QUERY: o_cmd.op = OP_QUERY;
            ACT_ENUM:  o_cmd.op = OP_ENUM;
            default:   o_cmd.op = OP_NOP;
        endcase
        idx_oor = IDX_EXT_W'(sel_idx) >= NW;
        o_cmd.oor = idx_oor && (o_cmd.op == OP_TEST || o_cmd.op == OP_SET ||
                                o_cmd.op == OP_OR || o_cmd.op == OP_ENUM);
        o_cmd.word_idx = sel_idx;
        o_cmd.bit_pos  = bit_index[5:0];
        o_cmd.value    = s_tdata[81:18];
    end

endmodule

@@ design/bme_queue.sv @@
// ============================================================================
// bme_queue
// Short command queue between the front and the back.
// ============================================================================
module bme_queue
    import bme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

@@ design/bme_back.sv @@
// ============================================================================
// bme_back
// Executes commands against the word store and member count, and drives the
// registered result stream. Enumeration emits one member per cycle while the result stream is not stalled.
// ============================================================================
module bme_back
    import bme_pkg::*;
#(
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // flag[0], out_of_range[1], is_empty[2], at_least_two[3],
    // member_index[15:4], member_valid[16], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

    logic [WORD_W-1:0] r_store [NUM_WORDS];

    t_bstate           r_state;
    t_bstate           n_state;
    logic [AW-1:0]     r_sweep_addr;
    t_cmd              r_cmd;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_word;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic              r_out_valid;
    t_result           r_res;
    logic              r_last;

    logic              out_free;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              emit;
    logic              emit_last;
    t_result           emit_res;
    logic              word_load;
    logic [WORD_W-1:0] fresh;
    logic [WORD_W-1:0] rest;
    logic [POPC_W-1:0] add_cnt;
    logic [COUNT_W:0]  cnt_sum;
    logic              enum_go;

    assign out_free = !r_out_valid || m_tready;
    assign fresh    = r_cmd.value & ~r_rdata;
    assign rest     = r_word & (r_word - WORD_W'(1));
    assign cnt_sum  = {1'b0, r_count} + (COUNT_W+1)'(add_cnt);
    assign enum_go  = !r_cmd.oor && (r_rdata != '0);
    assign rd_addr  = AW'(i_cmd.word_idx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_sweep_addr == LAST_ADDR) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!i_q_empty) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    priority if (r_cmd.op == OP_CLEAR) begin
                        n_state = ST_SWEEP;
                    end else if (r_cmd.op == OP_ENUM && enum_go) begin
                        n_state = ST_ENUM;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_ENUM: begin
                if (out_free && rest == '0) begin
                    n_state = ST_FETCH;
                end
            end
            default: n_state = ST_FETCH;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = AW'(r_cmd.word_idx);
        wr_data   = r_rdata;
        emit      = 1'b0;
        emit_last = 1'b1;
        emit_res  = '0;
        word_load = 1'b0;
        add_cnt   = '0;
        n_count   = r_count;
        unique case (r_state)
            ST_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep_addr;
                wr_data = '0;
            end
            ST_FETCH: begin
                o_pop = !i_q_empty;
                rd_en = !i_q_empty && !i_cmd.oor;
            end
            ST_EXEC: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_res.oor = r_cmd.oor;
                    unique case (r_cmd.op)
                        OP_TEST: begin
                            emit_res.flag = !r_cmd.oor && r_rdata[r_cmd.bit_pos];
                        end
                        OP_SET: begin
                            if (!r_cmd.oor && !r_rdata[r_cmd.bit_pos]) begin
                                emit_res.flag = 1'b1;
                                wr_en         = 1'b1;
                                wr_data       = r_rdata | (WORD_W'(1) << r_cmd.bit_pos);
                                add_cnt       = POPC_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_OR: begin
                            if (!r_cmd.oor && fresh != '0) begin
                                emit_res.flag = 1'b1;
                                wr_en         = 1'b1;
                                wr_data       = r_rdata | fresh;
                                add_cnt       = popcount(fresh);
                            end
                        end
                        OP_QUERY: begin
                            emit_res.is_empty     = r_count == '0;
                            emit_res.at_least_two = r_count >= COUNT_W'(2);
                        end
                        OP_ENUM: begin
                            if (enum_go) begin
                                emit      = 1'b0;
                                word_load = 1'b1;
                            end
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                    if (add_cnt != '0) begin
                        n_count = (cnt_sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX
                                                                      : cnt_sum[COUNT_W-1:0];
                    end
                end
            end
            ST_ENUM: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    emit_res.member_valid = 1'b1;
                    emit_res.member_index = {r_cmd.word_idx, lowest_bit(r_word)};
                    emit_last             = rest == '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (word_load) begin
            r_word <= r_rdata;
        end else if (r_state == ST_ENUM && out_free) begin
            r_word <= rest;
        end
        if (emit) begin
            r_res  <= emit_res;
            r_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_SWEEP) begin
                r_sweep_addr <= (r_sweep_addr == LAST_ADDR) ? '0
                                                            : r_sweep_addr + AW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(M_TDATA_W-RES_W)'(0), r_res};
    assign m_tlast  = r_last;

endmodule

@@ design/bitset_membership_engine_top.sv @@
// ============================================================================
// bitset_membership_engine_top
// Fixed-capacity bitset of NUM_WORDS 64-bit words with test, set, OR-word,
// clear-all, count query and per-word member enumeration.
// ============================================================================
// Flow: the fetch state pops an item and reads its store word; the exec state
// modifies and writes the word back and registers the result, holding while
// the result stream is stalled. An enumeration loads the word in the exec state
// and then emits one member per cycle while the stream is not stalled; clear all
// starts a clearing pass over every word. Reset: control state cleared, then a
// clearing pass zeroes the store; up to 2 items are queued meanwhile.
// ============================================================================
module bitset_membership_engine_top
    import bme_pkg::*;
#(
    parameter int NUM_WORDS = NUM_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bit_index[11:0], word_index[17:12], word_value[81:18], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // flag[0], out_of_range[1], is_empty[2], at_least_two[3],
    // member_index[15:4], member_valid[16], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd head_cmd;

    bme_front #(
        .NUM_WORDS (NUM_WORDS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    bme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    bme_back #(
        .NUM_WORDS (NUM_WORDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for bitset_membership_engine_top. A shadow copy of the
// bit store and member count predicts every result of each accepted input
// transaction. The checker compares each output transaction field by field
// against the oldest prediction. Directed tests come first. Random traffic
// follows in four phases that vary the idling on the slave and master sides.
// ============================================================================
module tb_top;
    import bme_pkg::*;

    localparam int NUM_WORDS = NUM_WORDS_DEF;
    localparam int MEMBER_CAP = 8191;
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                 flag;
        logic                 oor;
        logic                 is_empty;
        logic                 at_least_two;
        logic [BIT_IDX_W-1:0] member_index;
        logic                 member_valid;
        logic                 last;
    } t_member_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic [WORD_W-1:0] shadow_store [NUM_WORDS];
    int                shadow_count;
    t_member_result    pending_results [$];
    int                fail_count;
    int                src_idle_pct;
    int                snk_stall_pct;
    int                src_burst;
    int                snk_burst;
    int                sent_actions;

    bitset_membership_engine_top #(
        .NUM_WORDS(NUM_WORDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("bitset_membership_engine_top verification failed");
        $finish;
    end

    function automatic t_member_result blank_result();
        t_member_result r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_action(input logic [ACTION_W-1:0] act,
                                  input logic [BIT_IDX_W-1:0] bit_idx,
                                  input logic [IDX_W-1:0] word_idx,
                                  input logic [WORD_W-1:0] value);
        t_member_result    r;
        logic [IDX_W-1:0]  bw;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] fresh;
        logic [WORD_W-1:0] x;
        int                total;
        int                k;
        r   = blank_result();
        bw  = bit_idx[BIT_IDX_W-1:POS_W];
        pos = bit_idx[POS_W-1:0];
        case (act)
            ACT_TEST: begin
                if (int'(bw) >= NUM_WORDS) r.oor = 1'b1;
                else r.flag = shadow_store[bw][pos];
                pending_results.push_back(r);
            end
            ACT_SET: begin
                if (int'(bw) >= NUM_WORDS) begin
                    r.oor = 1'b1;
                end else if (!shadow_store[bw][pos]) begin
                    shadow_store[bw][pos] = 1'b1;
                    shadow_count = (shadow_count + 1 > MEMBER_CAP) ? MEMBER_CAP
                                                                   : shadow_count + 1;
                    r.flag = 1'b1;
                end
                pending_results.push_back(r);
            end
            ACT_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = '0;
                shadow_count = 0;
                pending_results.push_back(r);
            end
            ACT_OR: begin
                if (int'(word_idx) >= NUM_WORDS) begin
                    r.oor = 1'b1;
                end else begin
                    fresh = value & ~shadow_store[word_idx];
                    if (fresh != '0) begin
                        shadow_store[word_idx] |= fresh;
                        shadow_count += $countones(fresh);
                        if (shadow_count > MEMBER_CAP) shadow_count = MEMBER_CAP;
                        r.flag = 1'b1;
                    end
                end
                pending_results.push_back(r);
            end
            ACT_QUERY: begin
                r.is_empty     = (shadow_count == 0);
                r.at_least_two = (shadow_count >= 2);
                pending_results.push_back(r);
            end
            ACT_ENUM: begin
                if (int'(word_idx) >= NUM_WORDS) begin
                    r.oor = 1'b1;
                    pending_results.push_back(r);
                end else if (shadow_store[word_idx] == '0) begin
                    pending_results.push_back(r);
                end else begin
                    x     = shadow_store[word_idx];
                    total = $countones(x);
                    k     = 0;
                    for (int i = 0; i < WORD_W; i++) begin
                        if (x[i]) begin
                            k++;
                            r = '0;
                            r.member_index = BIT_IDX_W'(int'(word_idx) * WORD_W + i);
                            r.member_valid = 1'b1;
                            r.last         = (k == total);
                            pending_results.push_back(r);
                        end
                    end
                end
            end
            default: begin
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Called at a falling edge; returns at a falling edge with tvalid low.
    task automatic send_action(input logic [ACTION_W-1:0] act,
                               input logic [BIT_IDX_W-1:0] bit_idx,
                               input logic [IDX_W-1:0] word_idx,
                               input logic [WORD_W-1:0] value);
        if (src_burst > 0) begin
            src_burst--;
        end else begin
            if ($urandom_range(0, 31) == 0) src_burst = $urandom_range(4, 16);
            while ($urandom_range(0, 99) < src_idle_pct) begin
                s_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {6'b0, value, word_idx, bit_idx};
        do @(posedge i_clk); while (!s_tready);
        predict_action(act, bit_idx, word_idx, value);
        if (act <= ACT_ENUM) sent_actions++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    initial begin
        m_tready  = 1'b0;
        snk_burst = 0;
        forever begin
            @(negedge i_clk);
            if (snk_burst > 0) begin
                snk_burst--;
                m_tready = 1'b1;
            end else begin
                if ($urandom_range(0, 47) == 0) snk_burst = $urandom_range(8, 32);
                m_tready = ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_member_result e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: tdata %0h", m_tdata);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("flag", 32'(e.flag), 32'(m_tdata[0]));
                check_field("out_of_range", 32'(e.oor), 32'(m_tdata[1]));
                check_field("is_empty", 32'(e.is_empty), 32'(m_tdata[2]));
                check_field("at_least_two", 32'(e.at_least_two), 32'(m_tdata[3]));
                check_field("member_index", 32'(e.member_index), 32'(m_tdata[15:4]));
                check_field("member_valid", 32'(e.member_valid), 32'(m_tdata[16]));
                check_field("pad", 32'(0), 32'(m_tdata[M_TDATA_W-1:17]));
                check_field("last", 32'(e.last), 32'(m_tlast));
            end
        end
    end

    task automatic test_membership();
        send_action(ACT_TEST, 12'd0, 6'd0, '0);
        send_action(ACT_SET, 12'd0, 6'd0, '0);
        send_action(ACT_SET, 12'd0, 6'd0, '0);
        send_action(ACT_SET, 12'd4095, 6'd63, '1);
        send_action(ACT_TEST, 12'd4095, 6'd0, '0);
        send_action(ACT_TEST, 12'd4094, 6'd63, '1);
        send_action(ACT_TEST, 12'd0, 6'd0, '0);
    endtask

    task automatic test_counts();
        send_action(ACT_QUERY, '1, '1, '1);
        send_action(ACT_CLEAR, '0, '0, '0);
        send_action(ACT_QUERY, '0, '0, '0);
        send_action(ACT_SET, 12'd1234, 6'd0, '0);
        send_action(ACT_QUERY, '0, '0, '0);
        send_action(ACT_CLEAR, '1, '1, '1);
    endtask

    task automatic test_or_word();
        send_action(ACT_OR, 12'd0, 6'd0, '1);
        send_action(ACT_OR, 12'd0, 6'd0, '1);
        send_action(ACT_OR, 12'd0, 6'd5, '0);
        send_action(ACT_OR, 12'd0, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
        send_action(ACT_OR, 12'd0, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_enumerate();
        send_action(ACT_ENUM, 12'd0, 6'd0, '0);
        send_action(ACT_ENUM, 12'd0, 6'd1, '0);
        send_action(ACT_ENUM, '1, 6'd63, '1);
    endtask

    task automatic test_unused_actions();
        send_action(ACT_SPARE_6, '1, '1, '1);
        send_action(ACT_SPARE_7, '1, '1, '1);
        send_action(ACT_QUERY, '0, '0, '0);
    endtask

    function automatic logic [IDX_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return IDX_W'($urandom_range(0, 3));
            1:       return 6'd63;
            default: return IDX_W'($urandom_range(0, NUM_WORDS - 1));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        logic [WORD_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return v & {$urandom, $urandom} & {$urandom, $urandom};
            1:       return v | {$urandom, $urandom};
            default: return v;
        endcase
    endfunction

    task automatic test_random_traffic(input int n_actions, input int idle_pct,
                                       input int stall_pct);
        logic [IDX_W-1:0] w;
        int               target;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        target        = sent_actions + n_actions;
        while (sent_actions < target) begin
            w = pick_word();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 6))
                        send_action(ACT_SET, {w, POS_W'($urandom_range(0, 63))},
                                    IDX_W'($urandom), {$urandom, $urandom});
                    send_action(ACT_ENUM, BIT_IDX_W'($urandom), w, {$urandom, $urandom});
                    send_action(ACT_TEST, {w, POS_W'($urandom_range(0, 63))},
                                IDX_W'($urandom), {$urandom, $urandom});
                end
                3, 4, 5: begin
                    send_action(ACT_OR, BIT_IDX_W'($urandom), w, pick_value());
                    send_action(ACT_QUERY, BIT_IDX_W'($urandom), IDX_W'($urandom),
                                {$urandom, $urandom});
                    if ($urandom_range(0, 1))
                        send_action(ACT_ENUM, BIT_IDX_W'($urandom), w, {$urandom, $urandom});
                end
                6: begin
                    if ($urandom_range(0, 5) == 0)
                        send_action(ACT_CLEAR, BIT_IDX_W'($urandom), IDX_W'($urandom),
                                    {$urandom, $urandom});
                    send_action(ACT_QUERY, BIT_IDX_W'($urandom), IDX_W'($urandom),
                                {$urandom, $urandom});
                end
                default: begin
                    send_action(ACTION_W'($urandom_range(0, 7)), BIT_IDX_W'($urandom),
                                IDX_W'($urandom), {$urandom, $urandom});
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        fail_count    = 0;
        shadow_count  = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        src_burst     = 0;
        sent_actions  = 0;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_membership();
        test_counts();
        test_or_word();
        test_enumerate();
        test_unused_actions();

        test_random_traffic(62, 0, 0);
        test_random_traffic(62, 69, 0);
        test_random_traffic(62, 0, 69);
        test_random_traffic(62, 36, 36);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("bitset_membership_engine_top verification clean");
        end else begin
            $display("bitset_membership_engine_top verification failed");
        end
        $finish;
    end

endmodule
